// ===== design/tthtc_pkg.sv =====
// ----------------------------------------------------------------------------
// tthtc_pkg: shared types and constants of the three tank heat timer controller
// Tank modes, command and register codes, reset values and the constants
// used to turn a millisecond count into whole seconds.
// ----------------------------------------------------------------------------
`default_nettype none

package tthtc_pkg;

  localparam int NUM_TANKS = 3;

  // Tank mode as seen on the result channel
  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_HEATING = 2'd1,
    MODE_ON      = 2'd2
  } tank_mode_t;

  // Input commands; code 3 is a no-op
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_DUR_ONE   = 2'd0;
  localparam logic [1:0] REG_DUR_TWO   = 2'd1;
  localparam logic [1:0] REG_DUR_THREE = 2'd2;
  localparam logic [1:0] REG_SETPOINT  = 2'd3;

  localparam logic [23:0] DUR_RESET      = 24'd600000;
  localparam logic [7:0]  SETPOINT_RESET = 8'd60;

  // ms / MS_PER_SECOND of a 24-bit count is exact as
  // (ms * ceil(2^SECS_SHIFT / MS_PER_SECOND)) >> SECS_SHIFT, since the
  // rounding error of the reciprocal stays below 2^clog2(MS_PER_SECOND).
  localparam int          MS_PER_SECOND = 1000;
  localparam int          SECS_SHIFT    = 24 + $clog2(MS_PER_SECOND);
  localparam logic [24:0] SECS_RECIP    =
    25'(((64'd1 << SECS_SHIFT) + 64'(MS_PER_SECOND - 1)) / 64'(MS_PER_SECOND));
  localparam logic [14:0] SECS_MAX      = 15'h7FFF;

endpackage

`default_nettype wire

// ===== design/tthtc_in_if.sv =====
// ----------------------------------------------------------------------------
// tthtc_in_if: command channel of the tank controller
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tthtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] tank_index;
  logic [7:0] temperature;

  modport source (output valid, output cmd, output tank_index, output temperature,
                  input ready);
  modport sink (input valid, input cmd, input tank_index, input temperature,
                output ready);
endinterface

`default_nettype wire

// ===== design/tthtc_out_if.sv =====
// ----------------------------------------------------------------------------
// tthtc_out_if: status channel of the tank controller
// Valid/ready channel carrying one status beat per command.
// ----------------------------------------------------------------------------
`default_nettype none

interface tthtc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  tank_one_state;
  logic [1:0]  tank_two_state;
  logic [1:0]  tank_three_state;
  logic [14:0] tank_one_secs_left;
  logic [14:0] tank_two_secs_left;
  logic [14:0] tank_three_secs_left;
  logic        temp_ok;

  modport source (output valid, output tank_one_state, output tank_two_state,
                  output tank_three_state, output tank_one_secs_left,
                  output tank_two_secs_left, output tank_three_secs_left,
                  output temp_ok, input ready);
  modport sink (input valid, input tank_one_state, input tank_two_state,
                input tank_three_state, input tank_one_secs_left,
                input tank_two_secs_left, input tank_three_secs_left,
                input temp_ok, output ready);
endinterface

`default_nettype wire

// ===== design/tthtc_ms_to_secs.sv =====
// ----------------------------------------------------------------------------
// tthtc_ms_to_secs: millisecond count to whole seconds
// Divides a 24-bit millisecond count by MS_PER_SECOND with a reciprocal
// multiply and saturates the result at the 15-bit maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module tthtc_ms_to_secs (
  input  logic [23:0] ms,
  output logic [14:0] secs
);

  logic [48:0] prod;
  logic [23:0] quot;

  // Divide through the reciprocal, then clamp to the field width
  assign prod = 49'(ms) * 49'(tthtc_pkg::SECS_RECIP);
  assign quot = 24'(prod >> tthtc_pkg::SECS_SHIFT);
  assign secs = (quot > 24'(tthtc_pkg::SECS_MAX)) ? tthtc_pkg::SECS_MAX : quot[14:0];

endmodule

`default_nettype wire

// ===== design/three_tank_heat_timer_controller.sv =====
// ----------------------------------------------------------------------------
// three_tank_heat_timer_controller: timer and heat control of three tanks
// Tank mode machines, countdowns and a two-stage status pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  carries one command beat (tick, start, stop) with a tank index and
//           the measured temperature. Send a tick beat once per millisecond.
//   out_bus returns exactly one status beat per command: the three tank modes,
//           the seconds left on each tank and the temperature-ok flag, all
//           taken after the command has been applied.
//   cfg_*   writes the three run times (ms) and the setpoint, one register per
//           cycle with cfg_we high; write only while no beats are in flight.
// Timing: the tank state is updated in the cycle a command is accepted; the
//   status beat passes the middle stage (state update), then the output stage
//   (ms-to-seconds multiply). One command is taken every cycle unless stalled.
// Reset (rst_n low, synchronous): all tanks Off, countdowns zero, run times
//   600000 ms, setpoint 60, both pipeline stages empty.
// Stall: when out_bus.ready is low the status beat holds; the middle stage
//   still fills, and in_bus.ready drops only once both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module three_tank_heat_timer_controller (
  input  logic               clk,
  input  logic               rst_n,
  tthtc_in_if.sink           in_bus,
  tthtc_out_if.source        out_bus,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  localparam int N = tthtc_pkg::NUM_TANKS;

  // Configuration
  logic [23:0] dur_r [N];
  logic [7:0]  setpoint_r;

  // Tank state
  tthtc_pkg::tank_mode_t mode_r [N];
  tthtc_pkg::tank_mode_t mode_nxt [N];
  logic [23:0]           cnt_r [N];
  logic [23:0]           cnt_nxt [N];

  // Middle stage
  logic                  s1_valid_r;
  tthtc_pkg::tank_mode_t s1_mode_r [N];
  logic [23:0]           s1_ms_r [N];
  logic                  s1_ok_r;
  logic                  ok_nxt;
  logic [23:0]           ms_nxt [N];

  // Output stage
  logic                  out_valid_r;
  tthtc_pkg::tank_mode_t out_mode_r [N];
  logic [14:0]           out_secs_r [N];
  logic                  out_ok_r;
  logic [14:0]           secs [N];

  logic in_accept;
  logic s1_adv;
  logic out_load;
  logic temp_hot;
  logic idx_ok;
  logic [23:0] dec;

  // Handshake: each stage advances when the one after it has room
  assign out_load  = !out_valid_r || out_bus.ready;
  assign s1_adv    = s1_valid_r && out_load;
  assign in_bus.ready = !s1_valid_r || out_load;
  assign in_accept = in_bus.valid && in_bus.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        dur_r[k] <= tthtc_pkg::DUR_RESET;
      end
      setpoint_r <= tthtc_pkg::SETPOINT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tthtc_pkg::REG_DUR_ONE:   dur_r[0] <= cfg_wdata;
        tthtc_pkg::REG_DUR_TWO:   dur_r[1] <= cfg_wdata;
        tthtc_pkg::REG_DUR_THREE: dur_r[2] <= cfg_wdata;
        tthtc_pkg::REG_SETPOINT:  setpoint_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Apply one command to the tank machines
  always_comb begin
    for (int k = 0; k < N; k++) begin
      mode_nxt[k] = mode_r[k];
      cnt_nxt[k]  = cnt_r[k];
    end
    dec      = '0;
    temp_hot = in_bus.temperature > setpoint_r;
    idx_ok   = in_bus.tank_index < 2'(N);
    case (in_bus.cmd)
      tthtc_pkg::CMD_TICK: begin
        // Count down running tanks and turn off those that reach zero
        for (int k = 0; k < N; k++) begin
          if (mode_r[k] == tthtc_pkg::MODE_ON) begin
            dec = (cnt_r[k] == '0) ? '0 : cnt_r[k] - 24'd1;
            cnt_nxt[k] = dec;
            if (dec == '0) begin
              mode_nxt[k] = tthtc_pkg::MODE_OFF;
            end
          end
        end
        // Then release heating tanks once hot enough
        for (int k = 0; k < N; k++) begin
          if (mode_nxt[k] == tthtc_pkg::MODE_HEATING &&
              (mode_nxt[0] == tthtc_pkg::MODE_OFF || temp_hot)) begin
            mode_nxt[k] = tthtc_pkg::MODE_ON;
            cnt_nxt[k]  = dur_r[k];
          end
        end
      end
      tthtc_pkg::CMD_START: begin
        if (idx_ok) begin
          if (mode_r[in_bus.tank_index] == tthtc_pkg::MODE_OFF) begin
            if (in_bus.tank_index == 2'd0) begin
              mode_nxt[0] = tthtc_pkg::MODE_HEATING;
            end else begin
              mode_nxt[in_bus.tank_index] = tthtc_pkg::MODE_ON;
              cnt_nxt[in_bus.tank_index]  = dur_r[in_bus.tank_index];
            end
          end else if (in_bus.tank_index == 2'd0 &&
                       mode_r[0] == tthtc_pkg::MODE_HEATING && temp_hot) begin
            mode_nxt[0] = tthtc_pkg::MODE_ON;
            cnt_nxt[0]  = dur_r[0];
          end
        end
      end
      tthtc_pkg::CMD_STOP: begin
        if (idx_ok) begin
          mode_nxt[in_bus.tank_index] = tthtc_pkg::MODE_OFF;
          cnt_nxt[in_bus.tank_index]  = '0;
        end
      end
      default: ;
    endcase

    // Status taken after the update
    ok_nxt = (mode_nxt[0] == tthtc_pkg::MODE_OFF) || temp_hot;
    for (int k = 0; k < N; k++) begin
      ms_nxt[k] = (mode_nxt[k] == tthtc_pkg::MODE_ON) ? cnt_nxt[k] : dur_r[k];
    end
  end

  // Tank state and middle stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        mode_r[k] <= tthtc_pkg::MODE_OFF;
        cnt_r[k]  <= '0;
      end
      s1_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        for (int k = 0; k < N; k++) begin
          mode_r[k]    <= mode_nxt[k];
          cnt_r[k]     <= cnt_nxt[k];
          s1_mode_r[k] <= mode_nxt[k];
          s1_ms_r[k]   <= ms_nxt[k];
        end
        s1_ok_r <= ok_nxt;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Seconds left, one divider per tank
  for (genvar g = 0; g < N; g++) begin : g_secs
    tthtc_ms_to_secs u_secs (
      .ms   (s1_ms_r[g]),
      .secs (secs[g])
    );
  end

  // Output stage: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        for (int k = 0; k < N; k++) begin
          out_mode_r[k] <= s1_mode_r[k];
          out_secs_r[k] <= secs[k];
        end
        out_ok_r <= s1_ok_r;
      end
    end
  end

  assign out_bus.valid                = out_valid_r;
  assign out_bus.tank_one_state       = out_mode_r[0];
  assign out_bus.tank_two_state       = out_mode_r[1];
  assign out_bus.tank_three_state     = out_mode_r[2];
  assign out_bus.tank_one_secs_left   = out_secs_r[0];
  assign out_bus.tank_two_secs_left   = out_secs_r[1];
  assign out_bus.tank_three_secs_left = out_secs_r[2];
  assign out_bus.temp_ok              = out_ok_r;

endmodule

`default_nettype wire

// ===== design/tthtc_checker.sv =====
// ----------------------------------------------------------------------------
// tthtc_checker: port-level checks of the tank controller
// Watches the command and status channels and flags broken behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module tthtc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  tank_one_state,
  input logic [1:0]  tank_two_state,
  input logic [1:0]  tank_three_state,
  input logic [14:0] tank_one_secs_left,
  input logic        temp_ok
);

  // An accepted command has its status beat valid once through the middle and output stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("status beat missing two cycles after command");

  // Tank one off always counts as temperature ok
  a_off_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tank_one_state == tthtc_pkg::MODE_OFF |-> temp_ok)
    else $error("temp_ok low with tank one off");

  // Only tank one can heat
  a_no_heat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> tank_two_state != tthtc_pkg::MODE_HEATING &&
                  tank_three_state != tthtc_pkg::MODE_HEATING)
    else $error("unheated tank reported heating");

  // A stalled status beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tank_one_state) &&
                                $stable(tank_one_secs_left))
    else $error("status beat changed while stalled");

endmodule

bind three_tank_heat_timer_controller tthtc_checker u_tthtc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_bus.valid),
  .in_ready           (in_bus.ready),
  .out_valid          (out_bus.valid),
  .out_ready          (out_bus.ready),
  .tank_one_state     (out_bus.tank_one_state),
  .tank_two_state     (out_bus.tank_two_state),
  .tank_three_state   (out_bus.tank_three_state),
  .tank_one_secs_left (out_bus.tank_one_secs_left),
  .temp_ok            (out_bus.temp_ok)
);

`default_nettype wire
